// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, held off during reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the next clock cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hw/rtl/vmrq_pkg.sv -----
// ----------------------------------------------------------------------------
// vmrq_pkg
// shared types and codes for the message ring queue
// ----------------------------------------------------------------------------
`default_nettype none
package vmrq_pkg;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_REFUSE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SIZE  = 2'd3;

    localparam logic CFG_SLOT_LIMIT = 1'b0;
    localparam logic CFG_BYTE_LIMIT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clear;      // empty the queue
        logic push_step;  // place / write phase of a push
        logic pop_step;   // pop phase
        logic load;       // capture descriptors
    } t_cmd;
endpackage
`default_nettype wire

// ----- hw/rtl/vmrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// vmrq_ctrl
// sequencer: a beat is loaded in S_LOAD and executed in S_EXEC in the cycle right after, never later
// ----------------------------------------------------------------------------
`default_nettype none
module vmrq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_mode,
    input  wire logic            i_cfg_we,
    output vmrq_pkg::t_cmd       o_cmd,
    output logic                 o_busy
);
    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_EXEC} t_state;
    t_state r_state;
    logic   r_mode;

    // state and registered mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_state <= S_LOAD;
                    r_mode  <= i_mode;
                end
                S_LOAD:  r_state <= S_EXEC;
                S_EXEC:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_cmd.clear      = i_cfg_we;
    assign o_cmd.load       = (r_state == S_LOAD);
    assign o_cmd.push_step  = (r_state == S_EXEC) && !r_mode;
    assign o_cmd.pop_step   = (r_state == S_EXEC) && r_mode;
endmodule
`default_nettype wire

// ----- hw/rtl/vmrq_dp.sv -----
// ----------------------------------------------------------------------------
// vmrq_dp
// slot ring, byte store and result register
// ----------------------------------------------------------------------------
`default_nettype none
module vmrq_dp #(
    parameter int SLOTS       = 16,
    parameter int STORE_BYTES = 4096
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  vmrq_pkg::t_cmd      i_cmd,
    input  wire logic           i_start_acc,
    input  wire logic           i_cfg_idx,
    input  wire logic [12:0]    i_cfg_data,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_first_byte,
    input  wire logic           i_last_byte,
    input  wire logic [12:0]    i_msg_size,
    output logic                o_done,
    output logic [1:0]          o_status,
    output logic [7:0]          o_out_byte,
    output logic                o_end_of_message,
    output logic [12:0]         o_head_length,
    output logic [4:0]          o_queued_count,
    output logic                o_is_empty
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = $clog2(STORE_BYTES);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = $clog2(STORE_BYTES + 1);

    logic [CW-1:0] r_slot_limit;
    logic [LW-1:0] r_byte_limit;
    logic [SW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_held;
    logic [LW-1:0] r_start [SLOTS];
    logic [LW-1:0] r_len   [SLOTS];
    logic [7:0]    r_store [STORE_BYTES];
    logic [LW-1:0] r_push_off, r_pop_off;
    logic          r_acc;
    // captured beat
    logic [7:0]    r_d;
    logic          r_f, r_l;
    logic [12:0]   r_sz;
    // loaded descriptors
    logic [LW-1:0] r_front, r_back_start, r_back_end, r_cur_start, r_cur_len;
    logic [LW-1:0] r_hd_len;
    logic [7:0]    r_rbyte;

    logic [SW-1:0] back_idx, nwr, nrd;
    logic [SW:0]   wr_inc, rd_inc;
    logic [12:0]   cfg_slot_v, cfg_byte_v;

    always_comb begin
        back_idx = (r_wr == '0) ? SW'(r_slot_limit - CW'(1)) : r_wr - SW'(1);
        wr_inc   = {1'b0, r_wr} + (SW+1)'(1);
        rd_inc   = {1'b0, r_rd} + (SW+1)'(1);
        nwr      = ((SW+1+CW)'(wr_inc) >= (SW+1+CW)'(r_slot_limit)) ? '0 : wr_inc[SW-1:0];
        nrd      = ((SW+1+CW)'(rd_inc) >= (SW+1+CW)'(r_slot_limit)) ? '0 : rd_inc[SW-1:0];
        cfg_slot_v = {8'd0, i_cfg_data[4:0]};
        if (cfg_slot_v < 13'd1) cfg_slot_v = 13'd1;
        if (32'(cfg_slot_v) > SLOTS) cfg_slot_v = 13'(SLOTS);
        cfg_byte_v = i_cfg_data;
        if (cfg_byte_v < 13'd1) cfg_byte_v = 13'd1;
        if (32'(cfg_byte_v) > STORE_BYTES) cfg_byte_v = 13'(STORE_BYTES);
    end

    // placement decision, from loaded descriptors
    logic          place_ok;
    logic [LW-1:0] place_start;
    logic [LW+1:0] tail_sum;
    always_comb begin
        tail_sum    = (LW+2)'(r_back_end) + (LW+2)'(r_sz);
        place_ok    = 1'b1;
        place_start = '0;
        if (r_held >= r_slot_limit) begin
            place_ok = 1'b0;
        end else if (r_held != '0) begin
            if (r_back_start < r_front) begin
                if (tail_sum > (LW+2)'(r_front)) place_ok = 1'b0;
                else place_start = r_back_end;
            end else if (tail_sum <= (LW+2)'(r_byte_limit)) begin
                place_start = r_back_end;
            end else if ((LW+2)'(r_sz) <= (LW+2)'(r_front)) begin
                place_start = '0;
            end else begin
                place_ok = 1'b0;
            end
        end
    end

    logic [LW-1:0] wlen, wstart, n_next;
    logic          go, bad_size, commit, ends_msg;
    logic [1:0]    pstat, push_stat;
    always_comb begin
        bad_size = (r_sz == 13'd0) || ((LW+13)'(r_sz) > (LW+13)'(r_byte_limit));
        go       = 1'b0;
        pstat    = vmrq_pkg::ST_OK;
        wlen     = r_cur_len;
        wstart   = r_cur_start;
        if (r_f) begin
            if (bad_size) pstat = vmrq_pkg::ST_SIZE;
            else if (!place_ok) pstat = vmrq_pkg::ST_REFUSE;
            else begin
                go     = 1'b1;
                wlen   = LW'(r_sz);
                wstart = place_start;
            end
        end else if (!r_acc) begin
            pstat = vmrq_pkg::ST_REFUSE;
        end else begin
            go = 1'b1;
        end
        n_next    = (r_f ? '0 : r_push_off) + LW'(1);
        // message ends on this byte: committed only on a clean length match
        ends_msg  = go && ((n_next >= wlen) || r_l);
        commit    = go && (n_next == wlen) && r_l;
        push_stat = (ends_msg && !commit) ? vmrq_pkg::ST_REFUSE : pstat;
    end

    // last byte of the head message
    logic pop_last;
    assign pop_last = (r_pop_off + LW'(1) >= r_hd_len);

    // store: written on push, read into r_rbyte at load
    logic [LW-1:0] waddr_full, raddr_full;
    assign waddr_full = wstart + (r_f ? '0 : r_push_off);
    assign raddr_full = r_start[r_rd] + r_pop_off;
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_step && go) r_store[waddr_full[AW-1:0]] <= r_d;
        if (i_cmd.load) r_rbyte <= r_store[raddr_full[AW-1:0]];
    end

    // capture beat and descriptors
    always_ff @(posedge i_clk) begin
        if (i_start_acc) begin
            r_d  <= i_data_byte;
            r_f  <= i_first_byte;
            r_l  <= i_last_byte;
            r_sz <= i_msg_size;
        end
        if (i_cmd.load) begin
            r_front      <= r_start[r_rd];
            r_back_start <= r_start[back_idx];
            r_back_end   <= r_start[back_idx] + r_len[back_idx];
            r_cur_start  <= r_start[r_wr];
            r_cur_len    <= r_len[r_wr];
            r_hd_len     <= r_len[r_rd];
        end
    end

    // control state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= CW'(SLOTS);
            r_byte_limit <= LW'(STORE_BYTES);
            r_wr <= '0; r_rd <= '0; r_held <= '0;
            r_push_off <= '0; r_pop_off <= '0; r_acc <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_start[i] <= '0; r_len[i] <= '0;
            end
            o_done <= 1'b0;
            o_status <= '0; o_out_byte <= '0; o_end_of_message <= 1'b0;
            o_head_length <= '0; o_queued_count <= '0; o_is_empty <= 1'b1;
        end else begin
            o_done <= !i_cmd.clear && (i_cmd.push_step || i_cmd.pop_step);
            if (i_cmd.clear) begin
                if (i_cfg_idx == vmrq_pkg::CFG_SLOT_LIMIT) r_slot_limit <= CW'(cfg_slot_v);
                else r_byte_limit <= LW'(cfg_byte_v);
                r_wr <= '0; r_rd <= '0; r_held <= '0;
                r_push_off <= '0; r_pop_off <= '0; r_acc <= 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    r_start[i] <= '0; r_len[i] <= '0;
                end
            end else if (i_cmd.push_step) begin
                o_out_byte <= '0; o_end_of_message <= 1'b0; o_head_length <= '0;
                o_status <= push_stat;
                o_queued_count <= commit ? 5'(r_held + CW'(1)) : 5'(r_held);
                o_is_empty <= !commit && (r_held == '0);
                if (r_f && go) begin
                    r_start[r_wr] <= wstart;
                    r_len[r_wr]   <= wlen;
                end
                if (commit) begin
                    r_wr <= nwr;
                    r_held <= r_held + CW'(1);
                end
                if (!go || ends_msg) begin
                    r_acc <= 1'b0; r_push_off <= '0;
                end else begin
                    r_acc <= 1'b1; r_push_off <= n_next;
                end
            end else if (i_cmd.pop_step) begin
                if (r_held == '0) begin
                    o_status <= vmrq_pkg::ST_EMPTY;
                    o_out_byte <= '0; o_head_length <= '0; o_end_of_message <= 1'b0;
                    o_queued_count <= 5'(r_held);
                    o_is_empty <= 1'b1;
                end else begin
                    o_status <= vmrq_pkg::ST_OK;
                    o_out_byte <= r_rbyte;
                    o_head_length <= 13'(r_hd_len);
                    if (pop_last) begin
                        o_end_of_message <= 1'b1;
                        r_start[r_rd] <= '0; r_len[r_rd] <= '0;
                        r_rd <= nrd;
                        r_held <= r_held - CW'(1);
                        o_queued_count <= 5'(r_held - CW'(1));
                        o_is_empty <= (r_held == CW'(1));
                        r_pop_off <= '0;
                    end else begin
                        o_end_of_message <= 1'b0;
                        o_queued_count <= 5'(r_held);
                        o_is_empty <= 1'b0;
                        r_pop_off <= r_pop_off + LW'(1);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/variable_message_ring_queue_top.sv -----
// ----------------------------------------------------------------------------
// variable_message_ring_queue_top
// byte-wide queue of variable-length messages over a ring of slots
// ----------------------------------------------------------------------------
// channel   | handshake           | payload
// input     | i_start / o_busy    | i_mode i_data_byte i_first_byte i_last_byte i_msg_size
// result    | o_done (one cycle)  | o_status o_out_byte o_end_of_message o_head_length ...
// config    | i_cfg_we            | i_cfg_idx i_cfg_data
// each beat runs through capture, descriptor/store read, then execute
// o_done pulses in the cycle after the execute cycle; next start taken then
// reset empties the queue, limits go to SLOTS and STORE_BYTES
// the receiver cannot stall; the result is shown for one cycle
`default_nettype none
module variable_message_ring_queue_top #(
    parameter int SLOTS       = 16,
    parameter int STORE_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    input  wire logic        i_last_byte,
    input  wire logic [12:0] i_msg_size,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [12:0] i_cfg_data,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [7:0]       o_out_byte,
    output logic             o_end_of_message,
    output logic [12:0]      o_head_length,
    output logic [4:0]       o_queued_count,
    output logic             o_is_empty
);
    vmrq_pkg::t_cmd cmd;

    vmrq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start, .i_mode, .i_cfg_we,
        .o_cmd(cmd), .o_busy
    );

    vmrq_dp #(.SLOTS(SLOTS), .STORE_BYTES(STORE_BYTES)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_start_acc(i_start && !o_busy),
        .i_cfg_idx, .i_cfg_data,
        .i_data_byte, .i_first_byte, .i_last_byte, .i_msg_size,
        .o_done, .o_status, .o_out_byte, .o_end_of_message,
        .o_head_length, .o_queued_count, .o_is_empty
    );
endmodule
`default_nettype wire

// ----- hw/rtl/vmrq_checker.sv -----
// ----------------------------------------------------------------------------
// vmrq_checker
// port-level checks on the message ring queue
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module vmrq_props (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_done,
    input wire logic [1:0]  o_status,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_end_of_message,
    input wire logic [4:0]  o_queued_count,
    input wire logic        o_is_empty
);
    `CHK_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy,
        "start not taken")
    `CHK_IMPL(a_empty_match, i_clk, i_rst_n, o_done,
        o_is_empty == (o_queued_count == 5'd0), "empty flag")
    `CHK_IMPL(a_eom_ok, i_clk, i_rst_n, o_done && o_end_of_message,
        o_status == vmrq_pkg::ST_OK, "eom on fail")
    `CHK_IMPL(a_empty_pop_zero, i_clk, i_rst_n, o_done && o_status == vmrq_pkg::ST_EMPTY,
        o_out_byte == 8'd0, "byte on empty pop")
endmodule
bind variable_message_ring_queue_top vmrq_props u_chk (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_done, .o_status, .o_out_byte,
    .o_end_of_message, .o_queued_count, .o_is_empty
);
`default_nettype wire

// ----- test/vmrq_checker.sv -----
// ----------------------------------------------------------------------------
// vmrq_checker
// predicts each result beat of the message ring queue and compares it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module vmrq_checker #(
    parameter int SLOTS       = 16,
    parameter int STORE_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    input  wire logic        i_last_byte,
    input  wire logic [12:0] i_msg_size,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_done,
    input  wire logic [1:0]  i_status,
    input  wire logic [7:0]  i_out_byte,
    input  wire logic        i_end_of_message,
    input  wire logic [12:0] i_head_length,
    input  wire logic [4:0]  i_queued_count,
    input  wire logic        i_is_empty,
    output int               o_fail_count,
    output int               o_pending
);
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_byte;
        logic        eom;
        logic [12:0] head_len;
        logic [4:0]  count;
        logic        empty;
    } t_beat;

    t_beat expected_beats[$];

    // queue model state
    int          slot_lim, byte_lim;
    int          wr_slot, rd_slot, held;
    int          slot_base [SLOTS];
    int          slot_len  [SLOTS];
    logic [7:0]  store     [STORE_BYTES];
    int          push_ofs, pop_ofs;
    bit          pushing;

    assign o_pending = expected_beats.size();

    function automatic void empty_queue();
        wr_slot = 0; rd_slot = 0; held = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_base[i] = 0;
            slot_len[i]  = 0;
        end
        push_ofs = 0; pushing = 0; pop_ofs = 0;
    endfunction

    function automatic int step_slot(int i);
        return (i + 1 >= slot_lim) ? 0 : i + 1;
    endfunction

    // allocate a slot for a new message; 1 when refused
    function automatic bit place_fails(int size);
        int back, front, tail_end, base;
        base = 0;
        if (held >= slot_lim) return 1;
        if (held > 0) begin
            back     = (wr_slot + slot_lim - 1) % slot_lim;
            front    = slot_base[rd_slot];
            tail_end = slot_base[back] + slot_len[back];
            if (slot_base[back] < front) begin
                if (tail_end + size > front) return 1;
                base = tail_end;
            end else if (tail_end + size <= byte_lim) begin
                base = tail_end;
            end else if (size <= front) begin
                base = 0;
            end else begin
                return 1;
            end
        end
        slot_base[wr_slot] = base;
        slot_len[wr_slot]  = size;
        return 0;
    endfunction

    function automatic t_beat queue_step(bit mode, logic [7:0] data, bit first, bit last,
                                         int size);
        t_beat b;
        bit    go;
        int    n;
        b = '0;
        b.status = vmrq_pkg::ST_OK;
        if (!mode) begin
            go = 1;
            if (first) begin
                pushing = 0; push_ofs = 0;
                if (size == 0 || size > byte_lim) begin
                    b.status = vmrq_pkg::ST_SIZE; go = 0;
                end else if (place_fails(size)) begin
                    b.status = vmrq_pkg::ST_REFUSE; go = 0;
                end else begin
                    pushing = 1;
                end
            end else if (!pushing) begin
                b.status = vmrq_pkg::ST_REFUSE; go = 0;
            end
            if (go) begin
                store[(slot_base[wr_slot] + push_ofs) % STORE_BYTES] = data;
                n = push_ofs + 1;
                if (n >= slot_len[wr_slot] || last) begin
                    if (n == slot_len[wr_slot] && last) begin
                        wr_slot = step_slot(wr_slot);
                        held++;
                    end else begin
                        b.status = vmrq_pkg::ST_REFUSE;
                    end
                    pushing = 0; push_ofs = 0;
                end else begin
                    push_ofs = n;
                end
            end
        end else if (held == 0) begin
            b.status = vmrq_pkg::ST_EMPTY;
        end else begin
            b.head_len = 13'(slot_len[rd_slot]);
            b.out_byte = store[(slot_base[rd_slot] + pop_ofs) % STORE_BYTES];
            pop_ofs++;
            if (pop_ofs >= slot_len[rd_slot]) begin
                b.eom = 1;
                slot_base[rd_slot] = 0;
                slot_len[rd_slot]  = 0;
                rd_slot = step_slot(rd_slot);
                held--;
                pop_ofs = 0;
            end
        end
        b.count = 5'(held);
        b.empty = (held == 0);
        return b;
    endfunction

    function automatic int clamp(int v, int hi);
        return (v < 1) ? 1 : (v > hi) ? hi : v;
    endfunction

    // watch config, input and result beats
    always @(posedge i_clk) begin
        t_beat want;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            slot_lim = SLOTS;
            byte_lim = STORE_BYTES;
            empty_queue();
            expected_beats.delete();
            o_fail_count <= 0;
        end else begin
            if (i_done) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end else begin
                    want = expected_beats.pop_front();
                    if (i_status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, i_status);
                        errs++;
                    end
                    if (i_out_byte !== want.out_byte) begin
                        $error("out_byte exp %0d got %0d", want.out_byte, i_out_byte);
                        errs++;
                    end
                    if (i_end_of_message !== want.eom) begin
                        $error("end_of_message exp %0d got %0d", want.eom,
                               i_end_of_message);
                        errs++;
                    end
                    if (i_head_length !== want.head_len) begin
                        $error("head_length exp %0d got %0d", want.head_len,
                               i_head_length);
                        errs++;
                    end
                    if (i_queued_count !== want.count) begin
                        $error("queued_count exp %0d got %0d", want.count,
                               i_queued_count);
                        errs++;
                    end
                    if (i_is_empty !== want.empty) begin
                        $error("is_empty exp %0d got %0d", want.empty, i_is_empty);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            if (i_cfg_we) begin
                if (i_cfg_idx == vmrq_pkg::CFG_SLOT_LIMIT)
                    slot_lim = clamp(int'(i_cfg_data[4:0]), SLOTS);
                else
                    byte_lim = clamp(int'(i_cfg_data), STORE_BYTES);
                empty_queue();
            end
            if (i_start && !i_busy)
                expected_beats.push_back(queue_step(i_mode, i_data_byte, i_first_byte,
                                                    i_last_byte, int'(i_msg_size)));
        end
    end
endmodule
`default_nettype wire

// ----- test/tb_variable_message_ring_queue_top.sv -----
// ----------------------------------------------------------------------------
// tb_variable_message_ring_queue_top
// drives push and pop beats under several limits and idle patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_variable_message_ring_queue_top;
    localparam int SLOTS       = 16;
    localparam int STORE_BYTES = 4096;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BEATS = 180;

    logic        i_clk, i_rst_n, i_start, i_mode, i_first_byte, i_last_byte;
    logic [7:0]  i_data_byte;
    logic [12:0] i_msg_size, i_cfg_data;
    logic        i_cfg_we, i_cfg_idx;
    logic        o_busy, o_done, o_end_of_message, o_is_empty;
    logic [1:0]  o_status;
    logic [7:0]  o_out_byte;
    logic [12:0] o_head_length;
    logic [4:0]  o_queued_count;
    int          fail_count, pending, gap_pct, cur_bytes, sent;
    int          cycles = 0;

    variable_message_ring_queue_top #(.SLOTS(SLOTS), .STORE_BYTES(STORE_BYTES)) uut (.*);

    vmrq_checker #(.SLOTS(SLOTS), .STORE_BYTES(STORE_BYTES)) checker_i (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_mode, .i_data_byte,
        .i_first_byte, .i_last_byte, .i_msg_size, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_done(o_done), .i_status(o_status), .i_out_byte(o_out_byte),
        .i_end_of_message(o_end_of_message), .i_head_length(o_head_length),
        .i_queued_count(o_queued_count), .i_is_empty(o_is_empty),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    // cycle watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one input beat, held until taken; optional random gap first
    task automatic send_beat(bit mode, logic [7:0] data, bit first, bit last,
                             logic [12:0] size);
        while ($urandom_range(99) < gap_pct) @(negedge i_clk);
        i_start = 1'b1; i_mode = mode; i_data_byte = data;
        i_first_byte = first; i_last_byte = last; i_msg_size = size;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
        i_start = 1'b0;
        sent++;
    endtask

    task automatic push_msg(int len, int bad);
        for (int k = 0; k < len; k++)
            send_beat(1'b0, 8'($urandom), k == 0,
                      (bad == 1) ? (k == len - 2) : (bad == 2) ? 1'b0 : (k == len - 1),
                      13'(len));
    endtask

    task automatic pop_n(int n);
        for (int k = 0; k < n; k++) send_beat(1'b1, 8'($urandom), 1'($urandom), 1'($urandom),
                                              13'($urandom));
    endtask

    task automatic drain_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_reg(bit idx, logic [12:0] val);
        drain_idle();
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == vmrq_pkg::CFG_BYTE_LIMIT)
            cur_bytes = (val == 0) ? 1 : (val > STORE_BYTES) ? STORE_BYTES : int'(val);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 3) return cur_bytes;
        if (r < 6) return $urandom_range(cur_bytes + 3, 0);
        return $urandom_range((cur_bytes < 40) ? cur_bytes : 40, 1);
    endfunction

    initial begin
        int pct [4];
        int base;
        bit drained;
        pct = '{0, 65, 0, 17};
        gap_pct = 0; cur_bytes = STORE_BYTES; sent = 0;
        i_rst_n = 1'b0; i_start = 1'b0; i_mode = 1'b0; i_data_byte = '0;
        i_first_byte = 1'b0; i_last_byte = 1'b0; i_msg_size = '0;
        i_cfg_we = 1'b0; i_cfg_idx = vmrq_pkg::CFG_SLOT_LIMIT; i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pop, bad sizes, stray byte, mismatches, restart, extremes
        pop_n(1);
        send_beat(1'b0, 8'hff, 1'b1, 1'b1, 13'd0);
        send_beat(1'b0, 8'h00, 1'b1, 1'b1, 13'h1fff);
        send_beat(1'b0, 8'h5a, 1'b0, 1'b1, 13'd1);
        push_msg(3, 1);
        push_msg(2, 2);
        send_beat(1'b0, 8'h11, 1'b1, 1'b0, 13'd4);
        push_msg(2, 0);
        send_beat(1'b0, 8'hff, 1'b1, 1'b1, 13'd1);
        send_beat(1'b0, 8'h00, 1'b1, 1'b1, 13'd1);
        pop_n(5);
        set_reg(vmrq_pkg::CFG_SLOT_LIMIT, 13'd0);
        push_msg(1, 0); push_msg(1, 0); pop_n(2);
        set_reg(vmrq_pkg::CFG_BYTE_LIMIT, 13'd0);
        push_msg(1, 0); push_msg(2, 0); pop_n(2);
        set_reg(vmrq_pkg::CFG_SLOT_LIMIT, 13'h1fff);
        set_reg(vmrq_pkg::CFG_BYTE_LIMIT, 13'h1fff);

        // random phases over varied limits
        for (int ph = 0; ph < 8; ph++) begin
            gap_pct = pct[ph % 4];
            set_reg(vmrq_pkg::CFG_SLOT_LIMIT, 13'($urandom_range(17, 0)));
            set_reg(vmrq_pkg::CFG_BYTE_LIMIT,
                    (ph == 7) ? 13'd4096 : 13'($urandom_range(120, 8)));
            base = sent;
            drained = 1'b0;
            while (sent - base < PHASE_BEATS) begin
                case ($urandom_range(9))
                    0:       push_msg(pick_len(), $urandom_range(2, 1));
                    1:       send_beat(1'b0, 8'($urandom), 1'($urandom), 1'($urandom),
                                       13'($urandom));
                    2, 3, 4: push_msg(pick_len(), 0);
                    default: pop_n($urandom_range(12, 1));
                endcase
                // in phase 2, let every outstanding result come back once mid-phase
                if (ph == 2 && !drained && sent - base > PHASE_BEATS / 2) begin
                    drain_idle();
                    drained = 1'b1;
                end
            end
        end
        pop_n(40);

        drain_idle();
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/vmrq_pkg.sv
hw/rtl/vmrq_ctrl.sv
hw/rtl/vmrq_dp.sv
hw/rtl/variable_message_ring_queue_top.sv
hw/rtl/vmrq_checker.sv
test/vmrq_checker.sv
test/tb_variable_message_ring_queue_top.sv
